@@ rtl/core/erx_pkg.sv @@
package erx_pkg;

   // Buffer geometry and field widths.
   localparam int MAX_LEN   = 64;
   localparam int LEN_W     = 7;
   localparam int IDX_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;

   // Depth of the queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_BYTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE    = 2'd3;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'd48;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd255;
   localparam logic [BYTE_W-1:0] HEADER_BYTE_RST = 8'd1;
   localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd2;

   // Input transaction payload.
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              framing_error;
      logic              overrun_error;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic              write_enable;
      logic [IDX_W-1:0]  write_index;
      logic [BYTE_W-1:0] write_data;
      logic              packet_ready;
      logic [LEN_W-1:0]  packet_length;
      logic [BYTE_W-1:0] source_address;
      logic [BYTE_W-1:0] port_number;
   } rsp_type;

   // Current configuration.
   typedef struct packed {
      logic [BYTE_W-1:0] own_address;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] end_byte;
   } cfg_type;

   // A received byte together with its classification.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              err;
      logic              is_esc;
      logic              is_hdr;
      logic              is_own;
      logic              is_end;
   } tok_type;

   // Parser states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_ESC  = 3'd1,
      ST_HDR  = 3'd2,
      ST_SRC  = 3'd3,
      ST_PORT = 3'd4,
      ST_DATA = 3'd5,
      ST_DESC = 3'd6
   } parse_state_type;

endpackage

@@ rtl/core/escaped_packet_receiver.sv @@
// Escape-stuffed packet deframer for a serial receive path.
// The req_ channel carries one received byte per transaction with its framing
// and overrun flags; the rsp_ channel returns exactly one result per byte,
// giving the packet buffer write (enable, index, data) and the packet status
// (ready flag, length, source address and port number).
// The csr_ port writes own address, escape, header and end codes; it is to be
// written only while no transaction is in flight.
// The byte is loaded into the classifier register at acceptance, is written into
// the two-entry queue and then lands in the result register of the parser.
// Throughput is one byte per cycle while the receiver does not stall rsp_.
// Synchronous reset returns the parser to idle, clears the packet status and
// restores the default codes. When the receiver stalls rsp_, the result is
// held; the queue and the classifier register take up to three further bytes
// behind it before req_stall is raised.
module escaped_packet_receiver
   import erx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    f_valid;
   logic    f_ready;
   tok_type f_tok;
   logic    b_valid;
   logic    b_ready;
   tok_type b_tok;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_OWN_ADDRESS: cfg_in.own_address = csr_data;
            CSR_ESCAPE_BYTE: cfg_in.escape_byte = csr_data;
            CSR_HEADER_BYTE: cfg_in.header_byte = csr_data;
            CSR_END_BYTE:    cfg_in.end_byte    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address <= OWN_ADDRESS_RST;
         cfg_ff.escape_byte <= ESCAPE_BYTE_RST;
         cfg_ff.header_byte <= HEADER_BYTE_RST;
         cfg_ff.end_byte    <= END_BYTE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classifier front end.
   erx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .tok_valid (f_valid),
      .tok_ready (f_ready),
      .tok       (f_tok)
   );

   // Queue between classifier and parser.
   erx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_tok   (f_tok),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_tok    (b_tok)
   );

   // Parser back end with result register.
   erx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (b_valid),
      .tok_ready (b_ready),
      .tok       (b_tok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/erx_front.sv @@
module erx_front
   import erx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    tok_valid,
   input  logic    tok_ready,
   output tok_type tok
);

   logic    tok_valid_ff, tok_valid_in;
   tok_type tok_ff, tok_in;
   logic    accept;
   logic    push;

   // Stall only while the stage holds a byte that the queue cannot take.
   assign push      = tok_valid_ff && tok_ready;
   assign req_stall = tok_valid_ff && !tok_ready;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming byte against the configured codes.
   always_comb begin
      tok_in        = tok_ff;
      tok_valid_in  = tok_valid_ff;
      if (accept) begin
         tok_valid_in  = 1'b1;
         tok_in.data   = req_data.rx_byte;
         tok_in.err    = req_data.framing_error || req_data.overrun_error;
         tok_in.is_esc = (req_data.rx_byte == cfg.escape_byte);
         tok_in.is_hdr = (req_data.rx_byte == cfg.header_byte);
         tok_in.is_own = (req_data.rx_byte == cfg.own_address);
         tok_in.is_end = (req_data.rx_byte == cfg.end_byte);
      end else if (push) begin
         tok_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign tok_valid = tok_valid_ff;
   assign tok       = tok_ff;

endmodule

@@ rtl/core/erx_queue.sv @@
module erx_queue
   import erx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  tok_type push_tok,
   output logic    pop_valid,
   input  logic    pop_ready,
   output tok_type pop_tok
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tok_type           mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // Readiness comes from the fill count only, so no stall path runs through.
   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued transactions.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

@@ rtl/core/erx_back.sv @@
module erx_back
   import erx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   output logic    tok_ready,
   input  tok_type tok,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   parse_state_type   state_ff, state_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              ready_ff, ready_in;
   logic [BYTE_W-1:0] source_ff, source_in;
   logic [BYTE_W-1:0] port_ff, port_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              take;
   logic              wr_en;
   logic [LEN_W-1:0]  shrunk_len;

   // A transaction is parsed whenever the output register is free or draining.
   assign tok_ready  = !rsp_valid_ff || !rsp_stall;
   assign take       = tok_valid && tok_ready;
   assign shrunk_len = (length_ff != '0) ? length_ff - 1'b1 : '0;

   // Parser next state and packet status.
   always_comb begin
      state_in  = state_ff;
      length_in = length_ff;
      ready_in  = ready_ff;
      source_in = source_ff;
      port_in   = port_ff;
      wr_en     = 1'b0;
      if (take) begin
         if (tok.err) begin
            state_in = ST_IDLE;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (tok.is_esc) begin
                     state_in = ST_ESC;
                  end
               end
               ST_ESC: begin
                  state_in = tok.is_hdr ? ST_HDR : ST_IDLE;
               end
               ST_HDR: begin
                  // The address match takes priority over an escape.
                  if (tok.is_own) begin
                     state_in = ST_SRC;
                  end else if (tok.is_esc) begin
                     state_in = ST_ESC;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ST_SRC: begin
                  if (tok.is_esc) begin
                     state_in = ST_ESC;
                  end else begin
                     state_in  = ST_PORT;
                     source_in = tok.data;
                     ready_in  = 1'b0;
                     length_in = '0;
                  end
               end
               ST_PORT: begin
                  if (tok.is_esc) begin
                     state_in = ST_ESC;
                  end else begin
                     state_in = ST_DATA;
                     port_in  = tok.data;
                  end
               end
               ST_DATA: begin
                  if (length_ff < LEN_W'(MAX_LEN)) begin
                     wr_en     = 1'b1;
                     length_in = length_ff + 1'b1;
                     if (tok.is_esc) begin
                        state_in = ST_DESC;
                     end
                  end else begin
                     // Buffer full: drop this byte and close the packet.
                     length_in = shrunk_len;
                     ready_in  = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
               ST_DESC: begin
                  if (tok.is_esc) begin
                     state_in = ST_DATA;
                  end else if (tok.is_end) begin
                     // Remove the stored escape and mark the packet complete.
                     ready_in  = 1'b1;
                     length_in = shrunk_len;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end
   end

   // Result register, loaded with the state that follows each transaction.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in          = 1'b1;
         rsp_in.write_enable   = wr_en;
         rsp_in.write_index    = wr_en ? length_ff[IDX_W-1:0] : '0;
         rsp_in.write_data     = wr_en ? tok.data : '0;
         rsp_in.packet_ready   = ready_in;
         rsp_in.packet_length  = length_in;
         rsp_in.source_address = source_in;
         rsp_in.port_number    = port_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         ready_ff     <= 1'b0;
         source_ff    <= '0;
         port_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         ready_ff     <= ready_in;
         source_ff    <= source_in;
         port_ff      <= port_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ verif/erx_checker.sv @@
module erx_checker
   import erx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output int                   mismatch_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the configuration and of the parser state.
   cfg_type           cfg;
   parse_state_type   deframe_state;
   logic [LEN_W-1:0]  stored_len;
   logic              ready_flag;
   logic [BYTE_W-1:0] source_reg;
   logic [BYTE_W-1:0] port_reg;

   // Results still owed by the block, oldest first.
   rsp_type           expected_rsp_q[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Advances the shadow parser by one received byte and returns the result.
   function automatic rsp_type deframe_byte(input req_type item);
      rsp_type           res;
      logic [BYTE_W-1:0] b;
      res = '0;
      b   = item.rx_byte;
      if (item.framing_error || item.overrun_error) begin
         deframe_state = ST_IDLE;
      end else begin
         case (deframe_state)
            ST_IDLE: begin
               if (b == cfg.escape_byte) deframe_state = ST_ESC;
            end
            ST_ESC: begin
               deframe_state = (b == cfg.header_byte) ? ST_HDR : ST_IDLE;
            end
            ST_HDR: begin
               // The address match takes priority over an escape.
               if (b == cfg.own_address) deframe_state = ST_SRC;
               else if (b == cfg.escape_byte) deframe_state = ST_ESC;
               else deframe_state = ST_IDLE;
            end
            ST_SRC: begin
               if (b == cfg.escape_byte) begin
                  deframe_state = ST_ESC;
               end else begin
                  deframe_state = ST_PORT;
                  source_reg    = b;
                  ready_flag    = 1'b0;
                  stored_len    = '0;
               end
            end
            ST_PORT: begin
               if (b == cfg.escape_byte) begin
                  deframe_state = ST_ESC;
               end else begin
                  deframe_state = ST_DATA;
                  port_reg      = b;
               end
            end
            ST_DATA: begin
               if (stored_len < MAX_LEN) begin
                  res.write_enable = 1'b1;
                  res.write_index  = stored_len[IDX_W-1:0];
                  res.write_data   = b;
                  stored_len       = stored_len + 1'b1;
                  if (b == cfg.escape_byte) deframe_state = ST_DESC;
               end else begin
                  // Buffer full: the byte is dropped and the packet closes.
                  if (stored_len != '0) stored_len = stored_len - 1'b1;
                  ready_flag    = 1'b1;
                  deframe_state = ST_IDLE;
               end
            end
            ST_DESC: begin
               if (b == cfg.escape_byte) begin
                  deframe_state = ST_DATA;
               end else if (b == cfg.end_byte) begin
                  // The stored escape is taken back off the packet.
                  ready_flag = 1'b1;
                  if (stored_len != '0) stored_len = stored_len - 1'b1;
                  deframe_state = ST_IDLE;
               end else begin
                  deframe_state = ST_IDLE;
               end
            end
            default: begin
               deframe_state = ST_IDLE;
            end
         endcase
      end
      res.packet_ready   = ready_flag;
      res.packet_length  = stored_len;
      res.source_address = source_reg;
      res.port_number    = port_reg;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Watch both channels and the register port on every rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.own_address = OWN_ADDRESS_RST;
         cfg.escape_byte = ESCAPE_BYTE_RST;
         cfg.header_byte = HEADER_BYTE_RST;
         cfg.end_byte    = END_BYTE_RST;
         deframe_state   = ST_IDLE;
         stored_len      = '0;
         ready_flag      = 1'b0;
         source_reg      = '0;
         port_reg        = '0;
         expected_rsp_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OWN_ADDRESS: cfg.own_address = csr_data;
               CSR_ESCAPE_BYTE: cfg.escape_byte = csr_data;
               CSR_HEADER_BYTE: cfg.header_byte = csr_data;
               CSR_END_BYTE:    cfg.end_byte    = csr_data;
               default: ;
            endcase
         end
         // A result transaction is compared before this edge's input is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result transaction arrived with no expected result waiting");
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("write_enable", want.write_enable, rsp_data.write_enable);
               check_field("write_index", want.write_index, rsp_data.write_index);
               check_field("write_data", want.write_data, rsp_data.write_data);
               check_field("packet_ready", want.packet_ready, rsp_data.packet_ready);
               check_field("packet_length", want.packet_length, rsp_data.packet_length);
               check_field("source_address", want.source_address,
                           rsp_data.source_address);
               check_field("port_number", want.port_number, rsp_data.port_number);
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(deframe_byte(req_data));
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

@@ verif/tb_escaped_packet_receiver.sv @@
module tb_escaped_packet_receiver;
   timeunit 1ns;
   timeprecision 1ps;
   import erx_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_data = '0;
   int                   mismatch_count;
   int                   pending_count;

   // Stretches with no idling on either side.
   logic                 calm = 1'b0;
   int                   bytes_sent = 0;

   // Configuration currently loaded, used to build frames.
   logic [BYTE_W-1:0]    cur_own = OWN_ADDRESS_RST;
   logic [BYTE_W-1:0]    cur_esc = ESCAPE_BYTE_RST;
   logic [BYTE_W-1:0]    cur_hdr = HEADER_BYTE_RST;
   logic [BYTE_W-1:0]    cur_end = END_BYTE_RST;

   escaped_packet_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   erx_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always #2 clock = ~clock;

   // Offers one received byte and waits until the transaction is taken.
   task automatic send_rx(input logic [BYTE_W-1:0] b, input logic ferr, input logic oerr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_data.rx_byte       <= b;
      req_data.framing_error <= ferr;
      req_data.overrun_error <= oerr;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Sends a byte, corrupting its flags with the given chance in percent.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input int err_pct);
      send_rx(b, $urandom_range(0, 99) < err_pct, $urandom_range(0, 99) < err_pct);
   endtask

   function automatic logic [BYTE_W-1:0] random_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      b = random_byte();
      while (b == cur_esc) b = random_byte();
      return b;
   endfunction

   // Waits until every expected result has come back, then a few more cycles.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] own, input logic [BYTE_W-1:0] esc,
                             input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] eop);
      drain();
      write_reg(CSR_OWN_ADDRESS, own);
      write_reg(CSR_ESCAPE_BYTE, esc);
      write_reg(CSR_HEADER_BYTE, hdr);
      write_reg(CSR_END_BYTE, eop);
      csr_write_enable <= 1'b0;
      cur_own = own;
      cur_esc = esc;
      cur_hdr = hdr;
      cur_end = eop;
   endtask

   // One frame with random content, now and then broken along the way.
   task automatic send_frame(input int err_pct);
      int                n;
      logic [BYTE_W-1:0] b;
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      send_byte(cur_esc, err_pct);
      send_byte(($urandom_range(0, 19) == 0) ? random_byte() : cur_hdr, err_pct);
      send_byte(($urandom_range(0, 19) == 0) ? random_byte() : cur_own, err_pct);
      if ($urandom_range(0, 24) == 0) send_byte(cur_esc, err_pct);
      send_byte(plain_byte(), err_pct);
      if ($urandom_range(0, 24) == 0) send_byte(cur_esc, err_pct);
      send_byte(plain_byte(), err_pct);
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(0, 7) == 0) ? cur_esc : random_byte();
         send_byte(b, err_pct);
         // Escapes in the data are doubled, with the odd stray code after one.
         if (b == cur_esc) begin
            send_byte(($urandom_range(0, 29) == 0) ? random_byte() : cur_esc, err_pct);
         end
      end
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            send_byte(cur_esc, err_pct);
            send_byte(random_byte(), err_pct);
         end
         default: begin
            send_byte(cur_esc, err_pct);
            send_byte(cur_end, err_pct);
         end
      endcase
   endtask

   // Line noise, leaning towards the codes that the parser looks for.
   task automatic send_noise();
      int pick;
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: send_byte(cur_esc, 10);
            1: send_byte(cur_hdr, 10);
            2: send_byte(cur_own, 10);
            default: send_byte(random_byte(), 10);
         endcase
      end
   endtask

   task automatic random_phase(input int count);
      int target;
      int pick;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         calm = ($urandom_range(0, 7) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 75) send_frame(0);
         else if (pick < 85) send_frame(5);
         else send_noise();
      end
      calm = 1'b0;
   endtask

   // Result side: holds off each result for a random number of cycles.
   initial begin : rsp_side
      int hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A clean packet with byte extremes, a doubled escape and the end code.
      send_rx(8'hFF, 0, 0); send_rx(8'h01, 0, 0); send_rx(8'h30, 0, 0);
      send_rx(8'hAA, 0, 0); send_rx(8'h55, 0, 0); send_rx(8'h00, 0, 0);
      send_rx(8'hFF, 0, 0); send_rx(8'hFF, 0, 0); send_rx(8'h7F, 0, 0);
      send_rx(8'hFF, 0, 0); send_rx(8'h02, 0, 0);
      // Framing error, overrun, and both at once.
      send_rx(8'hFF, 1, 0); send_rx(8'hFF, 0, 1); send_rx(8'h00, 1, 1);
      // Escapes at the destination, source and port positions restart the frame.
      send_rx(8'hFF, 0, 0); send_rx(8'h01, 0, 0); send_rx(8'hFF, 0, 0);
      send_rx(8'h01, 0, 0); send_rx(8'h30, 0, 0); send_rx(8'hFF, 0, 0);
      send_rx(8'h01, 0, 0); send_rx(8'h30, 0, 0); send_rx(8'h11, 0, 0);
      send_rx(8'hFF, 0, 0);
      // Then a packet whose escape is followed by an unknown code.
      send_rx(8'h01, 0, 0); send_rx(8'h30, 0, 0); send_rx(8'h11, 0, 0);
      send_rx(8'h22, 0, 0); send_rx(8'hFF, 0, 0); send_rx(8'h44, 0, 0);

      random_phase(130);
      set_config(8'h00, 8'h00, 8'h00, 8'h00);
      random_phase(130);
      set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      random_phase(130);
      // Own address equal to the escape code.
      set_config(8'h7E, 8'h7E, 8'h81, 8'h00);
      random_phase(130);
      repeat (4) begin
         set_config(random_byte(), random_byte(), random_byte(), random_byte());
         random_phase(130);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/erx_pkg.sv
rtl/core/erx_front.sv
rtl/core/erx_queue.sv
rtl/core/erx_back.sv
rtl/core/escaped_packet_receiver.sv
verif/erx_checker.sv
verif/tb_escaped_packet_receiver.sv
